// ===== rtl/core/pst_pkg.sv =====
// Package for the priority schedule block: transaction types, field widths, control states.
package pst_pkg;

  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int JOBNUM_W = 4;
  localparam int TIME_W  = 20;
  localparam int TOTAL_W = 24;
  localparam int ELAPSED_W = 21;
  localparam int SUM_W   = 25;

  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  priority_req;
    logic               final_job;
  } pst_job_t;

  typedef struct packed {
    logic [JOBNUM_W-1:0] job_number;
    logic [BURST_W-1:0]  job_burst;
    logic [TIME_W-1:0]   completion_time;
    logic [TIME_W-1:0]   waiting_time;
    logic [TOTAL_W-1:0]  total_turnaround;
    logic [TOTAL_W-1:0]  total_waiting;
    logic                end_of_schedule;
  } pst_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_EMIT
  } pst_state_t;

endpackage

// ===== rtl/core/pst_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module pst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/priority_schedule_times.sv =====
// Top level: non-preemptive priority scheduler over a batch of buffered jobs.
//
//  channel | ports                          | transaction
//  --------+--------------------------------+---------------------------------------
//  job     | job_valid job_stall job_data   | one job: burst, priority, last-of-batch
//  res     | res_valid res_stall res_data   | one scheduled job with its timing
//
//  Loading takes one cycle per job; job_stall is high from the last job until
//  the final result of the batch has been loaded into the output register.
//  Each result takes a scan of the priority RAM through its single read port,
//  a burst RAM read and the output update.
//  rst is synchronous; RAM contents are not cleared. A stalled result holds
//  the block in the output step until it is taken.
module priority_schedule_times
  import pst_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     job_valid,
  output logic     job_stall,
  input  pst_job_t job_data,
  output logic     res_valid,
  input  logic     res_stall,
  output pst_res_t res_data
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam int KEY_W = PRIO_W + IDX_W;

  pst_state_t state, state_next;

  logic [CNT_W-1:0] job_count;
  logic [CNT_W-1:0] batch_n;
  logic [CNT_W-1:0] scan_i;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] k_plus;

  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic [PRIO_W-1:0] pri_rd;
  logic [BURST_W-1:0] bst_rd;

  logic [KEY_W-1:0] best_key;
  logic             best_valid;
  logic [KEY_W-1:0] prev_key;
  logic             prev_valid;
  logic [KEY_W-1:0] rd_key;
  logic             cand;

  logic [ELAPSED_W-1:0] elapsed;
  logic [ELAPSED_W-1:0] elapsed_next;
  logic [SUM_W-1:0]     sum_turn;
  logic [SUM_W-1:0]     sum_turn_next;
  logic [SUM_W-1:0]     sum_wait;
  logic [SUM_W-1:0]     sum_wait_next;

  logic             accept;
  logic             room;
  logic             issue;
  logic             scan_done;
  logic             emit_go;
  logic             last;
  logic             pri_re;
  logic             bst_re;
  logic [IDX_W-1:0] scan_addr;
  logic [IDX_W-1:0] best_idx;

  assign accept    = job_valid && !job_stall;
  assign room      = job_count < CNT_W'(MAX_PROCS);
  assign scan_addr = scan_i[IDX_W-1:0];
  assign best_idx  = best_key[IDX_W-1:0];
  assign k_plus    = k + 1'b1;
  assign last      = (k_plus == batch_n);
  assign scan_done = (scan_i == batch_n) && !rd_vld;
  assign emit_go   = (state == ST_EMIT) && (!res_valid || !res_stall);

  assign rd_key = {pri_rd, rd_idx};
  assign cand   = rd_vld && (!prev_valid || rd_key > prev_key) &&
                  (!best_valid || rd_key < best_key);

  assign elapsed_next  = elapsed + ELAPSED_W'(bst_rd);
  assign sum_turn_next = sum_turn + SUM_W'(elapsed_next);
  assign sum_wait_next = sum_wait + SUM_W'(elapsed);

  pst_ram #(.WIDTH(PRIO_W), .DEPTH(MAX_PROCS)) u_pri_ram (
    .clk   (clk),
    .we    (accept && room),
    .waddr (job_count[IDX_W-1:0]),
    .wdata (job_data.priority_req),
    .re    (pri_re),
    .raddr (scan_addr),
    .rdata (pri_rd)
  );

  pst_ram #(.WIDTH(BURST_W), .DEPTH(MAX_PROCS)) u_bst_ram (
    .clk   (clk),
    .we    (accept && room),
    .waddr (job_count[IDX_W-1:0]),
    .wdata (job_data.burst),
    .re    (bst_re),
    .raddr (best_idx),
    .rdata (bst_rd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && job_data.final_job) state_next = ST_SCAN;
      ST_SCAN:  if (scan_done) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) state_next = last ? ST_IDLE : ST_SCAN;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    job_stall = 1'b1;
    issue     = 1'b0;
    bst_re    = 1'b0;
    unique case (state)
      ST_IDLE:  job_stall = 1'b0;
      ST_SCAN:  issue = (scan_i < batch_n);
      ST_FETCH: bst_re = 1'b1;
      ST_EMIT:  job_stall = 1'b1;
      default:  job_stall = 1'b1;
    endcase
    pri_re = issue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      job_count  <= '0;
      batch_n    <= '0;
      scan_i     <= '0;
      k          <= '0;
      rd_vld     <= 1'b0;
      best_valid <= 1'b0;
      prev_valid <= 1'b0;
      elapsed    <= '0;
      sum_turn   <= '0;
      sum_wait   <= '0;
      res_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (issue) begin
        scan_i <= scan_i + 1'b1;
      end
      if (cand) begin
        best_valid <= 1'b1;
      end
      if (accept) begin
        if (job_data.final_job) begin
          job_count  <= '0;
          batch_n    <= room ? job_count + 1'b1 : job_count;
          scan_i     <= '0;
          k          <= '0;
          best_valid <= 1'b0;
          prev_valid <= 1'b0;
          elapsed    <= '0;
          sum_turn   <= '0;
          sum_wait   <= '0;
        end else if (room) begin
          job_count <= job_count + 1'b1;
        end
      end
      if (emit_go) begin
        res_valid  <= 1'b1;
        k          <= k_plus;
        scan_i     <= '0;
        best_valid <= 1'b0;
        prev_valid <= 1'b1;
        elapsed    <= elapsed_next;
        sum_turn   <= sum_turn_next;
        sum_wait   <= sum_wait_next;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cand) begin
      best_key <= rd_key;
    end
    if (issue) begin
      rd_idx <= scan_addr;
    end
    if (emit_go) begin
      prev_key                  <= best_key;
      res_data.job_number       <= JOBNUM_W'(best_idx);
      res_data.job_burst        <= bst_rd;
      res_data.completion_time  <= elapsed_next[TIME_W-1:0];
      res_data.waiting_time     <= elapsed[TIME_W-1:0];
      res_data.total_turnaround <= last ? sum_turn_next[TOTAL_W-1:0] : '0;
      res_data.total_waiting    <= last ? sum_wait_next[TOTAL_W-1:0] : '0;
      res_data.end_of_schedule  <= last;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    job_count <= CNT_W'(MAX_PROCS))
    else $error("job count beyond capacity");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> scan_i <= batch_n)
    else $error("scan index past batch size");

  a_fetch_found: assert property (@(posedge clk) disable iff (rst)
    state == ST_FETCH |-> best_valid)
    else $error("scan finished without a candidate");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    emit_go && last |=> state == ST_IDLE && res_valid && res_data.end_of_schedule)
    else $error("last result did not close the batch");
`endif

endmodule

// ===== tb/pst_sched_sb_pkg.sv =====
// Scoreboard for the priority scheduler: batch predictor and per-field result checks.
`timescale 1ns / 1ps
package pst_sched_sb_pkg;
  import pst_pkg::*;

  localparam int JOB_SLOTS = 16;

  class pst_sched_scoreboard;
    logic [BURST_W-1:0] burst_tab [JOB_SLOTS];
    logic [PRIO_W-1:0]  prio_tab  [JOB_SLOTS];
    int                 held;
    pst_res_t           schedule_q [$];
    int                 errors;
    int                 batches;
    int                 jobs_stored;
    int                 results_seen;

    function new();
      held         = 0;
      errors       = 0;
      batches      = 0;
      jobs_stored  = 0;
      results_seen = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function int pending();
      return schedule_q.size();
    endfunction

    // Store the job; on the last job of a batch, build the full schedule.
    function void note_job(pst_job_t j);
      int                   slot [JOB_SLOTS];
      int                   rank;
      logic [ELAPSED_W-1:0] clock_now;
      logic [ELAPSED_W-1:0] start;
      logic [SUM_W-1:0]     tat_sum;
      logic [SUM_W-1:0]     wait_sum;
      pst_res_t             r;
      if (held < JOB_SLOTS) begin
        burst_tab[held] = j.burst;
        prio_tab[held]  = j.priority_req;
        held++;
        jobs_stored++;
      end
      if (!j.final_job) return;
      // stable order: rank by lower priority, then earlier arrival
      for (int i = 0; i < held; i++) begin
        rank = 0;
        for (int k = 0; k < held; k++) begin
          if (prio_tab[k] < prio_tab[i] || (prio_tab[k] == prio_tab[i] && k < i)) rank++;
        end
        slot[rank] = i;
      end
      clock_now = '0;
      tat_sum   = '0;
      wait_sum  = '0;
      for (int n = 0; n < held; n++) begin
        start     = clock_now;
        clock_now = clock_now + ELAPSED_W'(burst_tab[slot[n]]);
        tat_sum   = tat_sum + SUM_W'(clock_now);
        wait_sum  = wait_sum + SUM_W'(start);
        r                 = '0;
        r.job_number      = JOBNUM_W'(slot[n]);
        r.job_burst       = burst_tab[slot[n]];
        r.completion_time = TIME_W'(clock_now);
        r.waiting_time    = TIME_W'(start);
        if (n == held - 1) begin
          r.total_turnaround = TOTAL_W'(tat_sum);
          r.total_waiting    = TOTAL_W'(wait_sum);
          r.end_of_schedule  = 1'b1;
        end
        schedule_q.push_back(r);
      end
      held = 0;
      batches++;
    endfunction

    task compare(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0h expected %0h", results_seen, field, got, want));
    endtask

    task check_result(pst_res_t got);
      pst_res_t want;
      results_seen++;
      if (schedule_q.size() == 0) begin
        report($sformatf("result %0d arrived with none expected (job %0h)",
                         results_seen, got.job_number));
        return;
      end
      want = schedule_q.pop_front();
      compare("job_number", 32'(got.job_number), 32'(want.job_number));
      compare("job_burst", 32'(got.job_burst), 32'(want.job_burst));
      compare("completion_time", 32'(got.completion_time), 32'(want.completion_time));
      compare("waiting_time", 32'(got.waiting_time), 32'(want.waiting_time));
      compare("total_turnaround", 32'(got.total_turnaround), 32'(want.total_turnaround));
      compare("total_waiting", 32'(got.total_waiting), 32'(want.total_waiting));
      compare("end_of_schedule", 32'(got.end_of_schedule), 32'(want.end_of_schedule));
    endtask

    task close_out();
      if (schedule_q.size() != 0)
        report($sformatf("%0d expected results never arrived", schedule_q.size()));
    endtask
  endclass

endpackage

// ===== tb/tb_priority_schedule_times.sv =====
// Testbench top for the priority scheduler: stimulus, handshake monitors and watchdog.
`timescale 1ns / 1ps
module tb_priority_schedule_times;
  import pst_pkg::*;
  import pst_sched_sb_pkg::*;

  localparam int RANDOM_JOBS = 470;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 400;

  logic     clk;
  logic     rst       = 1'b1;
  logic     job_valid = 1'b0;
  logic     job_stall;
  pst_job_t job_data  = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  pst_res_t res_data;

  pst_sched_scoreboard sb;
  int burst_left  = 0;
  int idle_cycles = 0;
  int stall_cyc   = 0;

  priority_schedule_times u_top (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job_data  (job_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver stall pattern, cycling through four modes
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1;
    case ((stall_cyc / 97) % 4)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 2) == 0);
      2: res_stall <= ((stall_cyc % 5) < 2);
      default: res_stall <= ((stall_cyc % 40) < 25);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && job_valid && !job_stall) sb.note_job(job_data);
    if (!rst && res_valid && !res_stall) sb.check_result(res_data);
    if (rst || (job_valid && !job_stall) || (res_valid && !res_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_job(input logic [BURST_W-1:0] b, input logic [PRIO_W-1:0] p,
                          input logic last, input bit drain);
    pst_job_t j;
    j.burst        = b;
    j.priority_req = p;
    j.final_job    = last;
    job_valid <= 1'b1;
    job_data  <= j;
    do @(posedge clk); while (job_stall);
    if (drain) begin
      job_valid <= 1'b0;
      do @(posedge clk); while (sb.pending() != 0);
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      job_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  initial begin
    int                 random_jobs;
    int                 size;
    logic [PRIO_W-1:0]  span;
    logic [BURST_W-1:0] b;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single zero job, then wait for the batch to drain
    send_job('0, '0, 1'b1, 1'b1);
    // full batch at maximum burst with tied priorities, then two loads past capacity
    for (int i = 0; i < 18; i++) begin
      if (i < JOB_SLOTS) send_job('1, (i % 2) ? 8'hFF : 8'h00, 1'b0, 1'b0);
      else send_job(16'h1234, 8'h00, i == 17, 1'b0);
    end
    // reversed priorities with a tie
    send_job(16'h0001, 8'd5, 1'b0, 1'b0);
    send_job(16'h8000, 8'd3, 1'b0, 1'b0);
    send_job(16'h0002, 8'd5, 1'b1, 1'b0);

    random_jobs = 0;
    while (random_jobs < RANDOM_JOBS) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
      span = $urandom_range(0, 1) ? 8'd3 : 8'd255;
      for (int i = 0; i < size; i++) begin
        case ($urandom_range(0, 5))
          0: b = '0;
          1: b = '1;
          default: b = BURST_W'($urandom_range(0, 65535));
        endcase
        send_job(b, PRIO_W'($urandom_range(0, span)), i == size - 1,
                 (i == size - 1) && ($urandom_range(0, 5) == 0));
      end
      random_jobs += (size > JOB_SLOTS) ? JOB_SLOTS : size;
    end
    job_valid <= 1'b0;

    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    sb.close_out();
    $display("Covered %0d batches of 1 to 20 loads (%0d jobs stored, overflow and ties included),",
             sb.batches, sb.jobs_stored);
    $display("%0d schedule results checked under sender gaps and receiver stalls.",
             sb.results_seen);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== priority_schedule_times.f =====
rtl/core/pst_pkg.sv
rtl/core/pst_ram.sv
rtl/core/priority_schedule_times.sv
tb/pst_sched_sb_pkg.sv
tb/tb_priority_schedule_times.sv
